// ===== sv/pvdd_pkg.sv =====
// Package: payload types and constants for the packed varint delta decoder.
`default_nettype none
package pvdd_pkg;

  // Longest varint that fits 64 bits: nine full groups plus one bit.
  localparam int unsigned MaxVarintBytes = 10;
  localparam int unsigned GroupBits      = 7;
  localparam int unsigned CountW         = 4;
  localparam int unsigned ValueW         = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last_of_block;
    logic              error;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/packed_varint_delta_decoder.sv =====
// Top level: packed protobuf varint decoder with zigzag delta accumulation or plain unsigned output.
// Output: a result is registered into the output register, or into the skid
//   register while the output register still holds an untaken result.
// Throughput: one byte per cycle while the skid register is empty; a two-entry output stage
//   (result register plus skid register) keeps input transfers going while a result waits.
// Reset (rst_ni low, async): varint state, running sum, mode and both output
//   entries clear; the block is ready (in_stall_o low) once reset is released.
`default_nettype none
module packed_varint_delta_decoder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // byte input
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire pvdd_pkg::in_t   in_data_i,
  // result output
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output pvdd_pkg::out_t       out_data_o,
  // mode register: 0 zigzag delta, 1 plain unsigned
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i
);

  localparam int unsigned CW = pvdd_pkg::CountW;
  localparam int unsigned VW = pvdd_pkg::ValueW;

  // Decoder state
  logic [CW-1:0] group_count_q, group_count_d;
  logic [VW-1:0] partial_q, partial_d;
  logic [VW-1:0] running_sum_q, running_sum_d;
  logic          overlong_q, overlong_d;
  logic          plain_mode_q;

  // Output stage: result register and skid register
  logic           out_valid_q, skid_valid_q;
  pvdd_pkg::out_t out_q, skid_q;

  logic           in_fire, out_take;
  logic           more, res_valid, res_err;
  logic [5:0]     shamt;
  logic [VW-1:0]  shifted, part_next, zigzag, sum_add;
  logic           overlong_next;
  pvdd_pkg::out_t res;

  // Skid full means the next result would have nowhere to go.
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign more    = in_data_i.data_byte[7];
  // Group k lands at bit 7k; for the tenth group only bit 0 survives the shift.
  assign shamt   = 6'(pvdd_pkg::GroupBits * group_count_q);
  assign shifted = {{(VW-pvdd_pkg::GroupBits){1'b0}}, in_data_i.data_byte[6:0]} << shamt;

  always_comb begin
    if (group_count_q < CW'(pvdd_pkg::MaxVarintBytes)) begin
      part_next     = partial_q | shifted;
      overlong_next = overlong_q;
    end else begin
      // Bytes past the tenth contribute nothing but flag the varint.
      part_next     = partial_q;
      overlong_next = 1'b1;
    end
  end

  // Zigzag: (u >> 1) ^ -(u & 1)
  assign zigzag  = {1'b0, part_next[VW-1:1]} ^ {VW{part_next[0]}};
  assign sum_add = running_sum_q + zigzag;

  // A result comes from a terminating byte or from any byte at block end.
  assign res_valid = in_fire && (!more || in_data_i.block_end);
  assign res_err   = more || overlong_next;

  always_comb begin
    res.last_of_block = in_data_i.block_end;
    res.error         = res_err;
    if (res_err) begin
      res.value = '0;
    end else if (plain_mode_q) begin
      res.value = part_next;
    end else begin
      res.value = sum_add;
    end
  end

  always_comb begin
    group_count_d = group_count_q;
    partial_d     = partial_q;
    overlong_d    = overlong_q;
    running_sum_d = running_sum_q;
    if (in_fire) begin
      if (res_valid) begin
        group_count_d = '0;
        partial_d     = '0;
        overlong_d    = 1'b0;
        if (in_data_i.block_end) begin
          running_sum_d = '0;
        end else if (!res_err && !plain_mode_q) begin
          running_sum_d = sum_add;
        end
      end else begin
        partial_d  = part_next;
        overlong_d = overlong_next;
        if (group_count_q < CW'(pvdd_pkg::MaxVarintBytes)) begin
          group_count_d = group_count_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= '0;
      partial_q     <= '0;
      overlong_q    <= 1'b0;
      running_sum_q <= '0;
      plain_mode_q  <= 1'b0;
    end else begin
      group_count_q <= group_count_d;
      partial_q     <= partial_d;
      overlong_q    <= overlong_d;
      running_sum_q <= running_sum_d;
      if (cfg_we_i) begin
        plain_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Output stage control. Input is stalled whenever the skid holds a result,
  // so a new result never competes with a skid drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  // Skid entry only exists behind a full result register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  // Error results carry a zero value.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error) |-> (out_data_o.value == '0))
    else $error("error result with nonzero value");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_count_q <= CW'(pvdd_pkg::MaxVarintBytes))
    else $error("group count past saturation");

  // Overlong flag only after the count has saturated.
  a_overlong_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    overlong_q |-> (group_count_q == CW'(pvdd_pkg::MaxVarintBytes)))
    else $error("overlong flag without saturated count");

  // Block end always clears the running sum.
  a_block_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.block_end) |=> (running_sum_q == '0))
    else $error("running sum not cleared at block end");

endmodule
`default_nettype wire
